>>> rtl/nfr_pkg.sv
package nfr_pkg;

  localparam int DATA_WIDTH_DEF   = 32;
  localparam int REFINE_STEPS_DEF = 3;

  localparam int SH_W   = 6;
  localparam int Z_W    = 64;
  localparam int HALF_W = Z_W / 2;
  localparam int IO_W   = 32;

  localparam logic [SH_W-1:0] SH_RESET = SH_W'(32);

  localparam logic [2:0] TAG_HALVE  = 3'd7;
  localparam logic [2:0] TAG_3Q_LO  = 3'd5;
  localparam logic [2:0] TAG_3Q_HI  = 3'd6;
  localparam int         SMALL_Q    = 3;
  localparam int         TAG_OFFSET = 2;

  typedef struct packed {
    logic div_zero;
    logic out_range;
  } flags_t;

  function automatic logic [Z_W-1:0] asr_one(input logic [Z_W-1:0] x);
    return {x[Z_W-1], x[Z_W-1:1]};
  endfunction

endpackage

>>> rtl/newton_fixed_point_reciprocal.sv
// Throughput: one transaction per cycle unless rsp_stall holds the output; each Newton step
// is a six-stage pipeline built around five 32x32 multipliers, and the seed takes two stages.
// A stalled response register holds its transaction while empty stages keep filling.
// Synchronous reset clears all valid bits and sets precision_shift to 32.
module newton_fixed_point_reciprocal #(
  parameter int DATA_WIDTH   = nfr_pkg::DATA_WIDTH_DEF,
  parameter int REFINE_STEPS = nfr_pkg::REFINE_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [nfr_pkg::SH_W-1:0]  cfg_wr_data,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [nfr_pkg::IO_W-1:0]  divisor,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic [nfr_pkg::IO_W-1:0]  reciprocal,
  output logic                      divide_by_zero,
  output logic                      out_of_range
);
  import nfr_pkg::*;

  localparam logic [IO_W-1:0] ONES = IO_W'((Z_W'(1) << DATA_WIDTH) - Z_W'(1));

  logic [SH_W-1:0]       precision_shift;
  logic                  seed_ready;
  logic                  ch_valid [REFINE_STEPS+1];
  logic                  ch_ready [REFINE_STEPS+1];
  logic [DATA_WIDTH-1:0] ch_q     [REFINE_STEPS+1];
  logic [Z_W-1:0]        ch_z     [REFINE_STEPS+1];
  flags_t                ch_flags [REFINE_STEPS+1];
  logic                  out_en;
  flags_t                last_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision_shift <= SH_RESET;
    end else if (cfg_wr_en) begin
      precision_shift <= cfg_wr_data;
    end
  end

  assign req_stall = ~seed_ready;

  nfr_seed #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_seed (
    .clk       (clk),
    .rst       (rst),
    .shift     (precision_shift),
    .up_valid  (req_valid),
    .up_ready  (seed_ready),
    .up_divisor(divisor),
    .dn_valid  (ch_valid[0]),
    .dn_ready  (ch_ready[0]),
    .dn_q      (ch_q[0]),
    .dn_z      (ch_z[0]),
    .dn_flags  (ch_flags[0])
  );

  for (genvar s = 0; s < REFINE_STEPS; s++) begin : g_step
    nfr_step #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .shift   (precision_shift),
      .up_valid(ch_valid[s]),
      .up_ready(ch_ready[s]),
      .up_q    (ch_q[s]),
      .up_z    (ch_z[s]),
      .up_flags(ch_flags[s]),
      .dn_valid(ch_valid[s+1]),
      .dn_ready(ch_ready[s+1]),
      .dn_q    (ch_q[s+1]),
      .dn_z    (ch_z[s+1]),
      .dn_flags(ch_flags[s+1])
    );
  end

  assign out_en                 = ~rsp_valid | ~rsp_stall;
  assign ch_ready[REFINE_STEPS] = out_en;
  assign last_flags             = ch_flags[REFINE_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_en) begin
      rsp_valid <= ch_valid[REFINE_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      divide_by_zero <= last_flags.div_zero;
      out_of_range   <= last_flags.out_range;
      if (last_flags.out_range) begin
        reciprocal <= '0;
      end else if (last_flags.div_zero) begin
        reciprocal <= ONES;
      end else begin
        reciprocal <= IO_W'(ch_z[REFINE_STEPS][DATA_WIDTH-1:0]);
      end
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(divide_by_zero && out_of_range))
    else $error("both result flags set");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && out_of_range) |-> (reciprocal == '0))
    else $error("out of range result not zero");

  a_zero_ones: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && divide_by_zero) |-> (reciprocal == ONES))
    else $error("zero divisor result not all ones");

endmodule

>>> rtl/nfr_seed.sv
module nfr_seed #(
  parameter int DATA_WIDTH = nfr_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [nfr_pkg::SH_W-1:0]  shift,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [nfr_pkg::IO_W-1:0]  up_divisor,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [DATA_WIDTH-1:0]     dn_q,
  output logic [nfr_pkg::Z_W-1:0]   dn_z,
  output nfr_pkg::flags_t           dn_flags
);
  import nfr_pkg::*;

  localparam int M_W = $clog2(DATA_WIDTH);

  logic                  v1, v2;
  logic                  en1, en2;
  logic [DATA_WIDTH-1:0] q_in;
  logic [M_W-1:0]        m_in;
  logic [DATA_WIDTH-1:0] q1;
  logic [M_W-1:0]        m1;
  flags_t                f1;
  logic [DATA_WIDTH-1:0] q_top;
  logic [2:0]            tag;
  logic [SH_W-1:0]       k;
  logic [Z_W-1:0]        z_pow;
  logic [Z_W-1:0]        z_half;
  logic [Z_W-1:0]        z_seed;
  logic [DATA_WIDTH-1:0] q2;
  logic [Z_W-1:0]        z2;
  flags_t                f2;

  assign q_in = up_divisor[DATA_WIDTH-1:0];

  always_comb begin
    m_in = '0;
    for (int i = 1; i < DATA_WIDTH; i++) begin
      if (q_in[i]) begin
        m_in = M_W'(i);
      end
    end
  end

  assign en2      = ~v2 | dn_ready;
  assign en1      = ~v1 | en2;
  assign up_ready = en1;

  always_comb begin
    q_top  = q1 >> (m1 - M_W'(TAG_OFFSET));
    tag    = (m1 >= M_W'(TAG_OFFSET)) ? q_top[2:0] : 3'd0;
    k      = shift - SH_W'(m1);
    z_pow  = Z_W'(1) << k;
    z_half = (tag == TAG_HALVE) ? asr_one(z_pow) : z_pow;
    if (tag == TAG_3Q_LO || tag == TAG_3Q_HI || q1 == DATA_WIDTH'(SMALL_Q)) begin
      z_seed = asr_one(z_half | asr_one(z_half));
    end else begin
      z_seed = z_half;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= up_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q1           <= q_in;
      m1           <= m_in;
      f1.div_zero  <= (q_in == '0);
      f1.out_range <= (q_in != '0) && (SH_W'(m_in) > shift);
    end
    if (en2) begin
      q2 <= q1;
      z2 <= z_seed;
      f2 <= f1;
    end
  end

  assign dn_valid = v2;
  assign dn_q     = q2;
  assign dn_z     = z2;
  assign dn_flags = f2;

endmodule

>>> rtl/nfr_step.sv
module nfr_step #(
  parameter int DATA_WIDTH = nfr_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [nfr_pkg::SH_W-1:0]  shift,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [DATA_WIDTH-1:0]     up_q,
  input  logic [nfr_pkg::Z_W-1:0]   up_z,
  input  nfr_pkg::flags_t           up_flags,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output logic [DATA_WIDTH-1:0]     dn_q,
  output logic [nfr_pkg::Z_W-1:0]   dn_z,
  output nfr_pkg::flags_t           dn_flags
);
  import nfr_pkg::*;

  logic                  v1, v2, v3, v4, v5, v6;
  logic                  en1, en2, en3, en4, en5, en6;
  logic [HALF_W-1:0]     q32;
  logic [DATA_WIDTH-1:0] q1, q2, q3, q4, q5, q6;
  logic [Z_W-1:0]        z1, z2, z3, z4, z5, z6;
  flags_t                f1, f2, f3, f4, f5, f6;
  logic [Z_W-1:0]        plo1;
  logic [HALF_W-1:0]     phi1;
  logic [Z_W-1:0]        t2;
  logic [Z_W-1:0]        r0_3;
  logic [HALF_W-1:0]     r1_3, r2_3;
  logic [Z_W-1:0]        rhs4;
  logic [Z_W-1:0]        diff5;

  assign q32 = HALF_W'(up_q);

  assign en6      = ~v6 | dn_ready;
  assign en5      = ~v5 | en6;
  assign en4      = ~v4 | en5;
  assign en3      = ~v3 | en4;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= up_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        v5 <= v4;
      end
      if (en6) begin
        v6 <= v5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q1   <= up_q;
      z1   <= up_z;
      f1   <= up_flags;
      plo1 <= Z_W'(q32) * Z_W'(up_z[HALF_W-1:0]);
      phi1 <= HALF_W'(q32 * up_z[Z_W-1:HALF_W]);
    end
    if (en2) begin
      q2 <= q1;
      z2 <= z1;
      f2 <= f1;
      t2 <= plo1 + {phi1, {HALF_W{1'b0}}};
    end
    if (en3) begin
      q3   <= q2;
      z3   <= z2;
      f3   <= f2;
      r0_3 <= Z_W'(t2[HALF_W-1:0]) * Z_W'(z2[HALF_W-1:0]);
      r1_3 <= HALF_W'(t2[HALF_W-1:0] * z2[Z_W-1:HALF_W]);
      r2_3 <= HALF_W'(t2[Z_W-1:HALF_W] * z2[HALF_W-1:0]);
    end
    if (en4) begin
      q4   <= q3;
      z4   <= z3;
      f4   <= f3;
      rhs4 <= r0_3 + {HALF_W'(r1_3 + r2_3), {HALF_W{1'b0}}};
    end
    if (en5) begin
      q5    <= q4;
      z5    <= z4;
      f5    <= f4;
      diff5 <= (z4 << shift) - rhs4;
    end
    if (en6) begin
      q6 <= q5;
      f6 <= f5;
      z6 <= z5 + Z_W'($signed(diff5) >>> shift);
    end
  end

  assign dn_valid = v6;
  assign dn_q     = q6;
  assign dn_z     = z6;
  assign dn_flags = f6;

endmodule
